@@ hdl/smeu_pkg.sv @@
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and constants
// Operation codes, status codes, emit kinds and the request/result payloads.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int unsigned OP_W = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned EDGE_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SIZE_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH    = 4'd0;
  localparam logic [OP_W-1:0] OP_POP     = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD     = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB     = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd5;
  localparam logic [OP_W-1:0] OP_MOD     = 4'd6;
  localparam logic [OP_W-1:0] OP_NOT     = 4'd7;
  localparam logic [OP_W-1:0] OP_GREATER = 4'd8;
  localparam logic [OP_W-1:0] OP_DUP     = 4'd9;
  localparam logic [OP_W-1:0] OP_ROLL    = 4'd10;
  localparam logic [OP_W-1:0] OP_INCHAR  = 4'd11;
  localparam logic [OP_W-1:0] OP_OUTNUM  = 4'd12;
  localparam logic [OP_W-1:0] OP_OUTCHAR = 4'd13;
  localparam logic [OP_W-1:0] OP_CHOOSE  = 4'd14;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd3;

  localparam logic [KIND_W-1:0] EMIT_NONE = 2'd0;
  localparam logic [KIND_W-1:0] EMIT_NUM  = 2'd1;
  localparam logic [KIND_W-1:0] EMIT_CHAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] operand;
    logic [EDGE_W-1:0]        edge_count;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [KIND_W-1:0]        emit_kind;
    logic signed [WORD_W-1:0] emit_value;
    logic [EDGE_W-1:0]        branch_index;
    logic [SIZE_W-1:0]        stack_size;
  } res_t;

  // Divider start request and result
  typedef struct packed {
    logic              start;
    logic              is_signed;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ hdl/smeu_if.sv @@
// ----------------------------------------------------------------------------
// smeu_cmd_if / smeu_res_if: valid/ready channels
// Carry one command request or one result with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface smeu_cmd_if;
  logic                   valid;
  logic                   ready;
  smeu_pkg::cmd_t         payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface smeu_res_if;
  logic                   valid;
  logic                   ready;
  smeu_pkg::res_t         payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/smeu_div.sv @@
// ----------------------------------------------------------------------------
// smeu_div: iterative divider
// Restoring divider, one quotient bit per cycle; signed (truncating) or
// unsigned operands. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module smeu_div (
  input  logic               clk,
  input  logic               rst,
  input  smeu_pkg::div_req_t req,
  output smeu_pkg::div_rsp_t rsp
);
  import smeu_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] quo;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;
  logic              done;
  logic [WORD_W:0]   rem_shift;
  logic [WORD_W:0]   rem_sub;
  logic [WORD_W-1:0] a_mag;
  logic [WORD_W-1:0] b_mag;

  // Magnitudes of the operands and the shifted trial subtraction
  always_comb begin
    a_mag = (req.is_signed && req.dividend[WORD_W-1]) ? (~req.dividend + 1'b1)
                                                      : req.dividend;
    b_mag = (req.is_signed && req.divisor[WORD_W-1]) ? (~req.divisor + 1'b1)
                                                     : req.divisor;
    rem_shift = {rem[WORD_W-1:0], quo[WORD_W-1]};
    rem_sub   = rem_shift - {1'b0, dvs};
  end

  // Shift and subtract one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(WORD_W);
        quo   <= a_mag;
        rem   <= '0;
        dvs   <= b_mag;
        neg_q <= req.is_signed && (req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1]);
        neg_r <= req.is_signed && req.dividend[WORD_W-1];
      end else if (busy) begin
        if (!rem_sub[WORD_W]) begin
          rem <= rem_sub;
          quo <= {quo[WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[WORD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply signs
  always_comb begin
    rsp.done = done;
    rsp.quot = neg_q ? (~quo + 1'b1) : quo;
    rsp.rem  = neg_r ? (~rem[WORD_W-1:0] + 1'b1) : rem[WORD_W-1:0];
  end

endmodule

@@ hdl/stack_machine_execution_unit.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execution_unit: stack-machine command executor
// Executes one command per request on a bounded stack of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (sink): one request carries operation, operand and edge_count.
//   res (source): exactly one result per request: status, emit_kind,
//   emit_value, branch_index and stack_size after the command.
// Sequence: every command reads the top two stack words from the stack RAM
//   (one read port, registered data) before it executes. div, mod and
//   choose with a nonzero edge_count then run the serial divider. roll
//   with a valid depth first reduces the roll count with the divider and,
//   unless it is zero, moves each of the depth entries through the RAM
//   in the states S_RRD, S_RWAIT and S_RWR.
// Throughput: one request at a time; cmd.ready is high only while idle and
//   the result register is empty or being taken.
// Reset: rst clears the stack count and control; the stack RAM needs no
//   clearing since values read from unwritten entries are never used.
// Stall: a result waits in the output register while res.ready is low; a
//   new request is taken once that register frees.
// ----------------------------------------------------------------------------
module stack_machine_execution_unit #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  smeu_cmd_if.sink    cmd,
  smeu_res_if.source  res
);
  import smeu_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_WAIT, S_EXEC, S_DIV, S_RMOD,
    S_RRD, S_RWAIT, S_RWR, S_DONE
  } state_t;

  state_t               state;
  logic [WORD_W-1:0]    mem [STACK_DEPTH];
  logic [WORD_W-1:0]    rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [AW-1:0]        wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [CW-1:0]        count;
  cmd_t                 cur;
  logic [WORD_W-1:0]    a;
  logic [WORD_W-1:0]    b;
  logic                 res_valid;
  res_t                 res_q;
  div_req_t             dreq;
  div_rsp_t             drsp;
  // roll bookkeeping
  logic [CW-1:0]        r_depth;
  logic [CW-1:0]        r_shift;
  logic [CW-1:0]        r_base;
  logic [CW-1:0]        r_src;
  logic [CW-1:0]        r_dst;
  logic [CW-1:0]        r_left;
  logic [CW-1:0]        r_start;
  logic [WORD_W-1:0]    r_hold;
  logic [CW:0]          r_sum;
  logic                 need1;
  logic                 need2;
  logic                 grows;
  logic [CW-1:0]        need;

  // Stack RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  smeu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign cmd.ready   = (state == S_IDLE) && (!res_valid || res.ready);
  assign res.valid   = res_valid;
  assign res.payload = res_q;

  // Decode stack needs of the current command
  always_comb begin
    need1 = 1'b0;
    need2 = 1'b0;
    grows = 1'b0;
    case (cur.operation) inside
      OP_PUSH, OP_INCHAR: grows = 1'b1;
      OP_POP, OP_NOT, OP_OUTNUM, OP_OUTCHAR, OP_CHOOSE: need1 = 1'b1;
      OP_DUP: begin
        need1 = 1'b1;
        grows = 1'b1;
      end
      [OP_ADD:OP_ROLL]: need2 = 1'b1;
      default: ;
    endcase
    need = need2 ? CW'(2) : (need1 ? CW'(1) : CW'(0));
  end

  // Source offset plus shift, one bit wider to keep the carry
  always_comb begin
    r_sum = {1'b0, r_src} + {1'b0, r_shift};
  end

  // Sequencer: hold state, RAM control and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      we        <= 1'b0;
      dreq      <= '0;
    end else begin
      we         <= 1'b0;
      dreq.start <= 1'b0;
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            cur     <= cmd.payload;
            rd_addr <= AW'(count - 1'b1);
            state   <= S_RD_A;
          end
        end
        S_RD_A: begin
          rd_addr <= AW'(count - CW'(2));
          state   <= S_RD_B;
        end
        S_RD_B: begin
          a     <= rd_data;
          state <= S_WAIT;
        end
        S_WAIT: begin
          b     <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_q <= '0;
          res_q.status <= ST_OK;
          res_q.stack_size <= SIZE_W'(count);
          state <= S_DONE;
          if (count < need) begin
            res_q.status <= ST_UNDER;
          end else if (grows && count >= CW'(STACK_DEPTH)) begin
            res_q.status <= ST_OVER;
          end else if ((cur.operation == OP_DIV || cur.operation == OP_MOD) &&
                       a == '0) begin
            res_q.status <= ST_DIV0;
          end else begin
            case (cur.operation)
              OP_PUSH, OP_INCHAR: begin
                we      <= 1'b1;
                wr_addr <= AW'(count);
                wr_data <= cur.operand;
                count   <= count + 1'b1;
              end
              OP_POP: count <= count - 1'b1;
              OP_ADD, OP_SUB, OP_MUL, OP_GREATER: begin
                we      <= 1'b1;
                wr_addr <= AW'(count - CW'(2));
                count   <= count - 1'b1;
                case (cur.operation)
                  OP_ADD: wr_data <= b + a;
                  OP_SUB: wr_data <= b - a;
                  OP_MUL: wr_data <= b * a;
                  default: wr_data <= ($signed(b) > $signed(a)) ? WORD_W'(1) : '0;
                endcase
              end
              OP_NOT: begin
                we      <= 1'b1;
                wr_addr <= AW'(count - 1'b1);
                wr_data <= (a == '0) ? WORD_W'(1) : '0;
              end
              OP_DUP: begin
                we      <= 1'b1;
                wr_addr <= AW'(count);
                wr_data <= a;
                count   <= count + 1'b1;
              end
              OP_OUTNUM, OP_OUTCHAR: begin
                res_q.emit_kind  <= (cur.operation == OP_OUTNUM) ? EMIT_NUM : EMIT_CHAR;
                res_q.emit_value <= a;
                count <= count - 1'b1;
              end
              OP_DIV, OP_MOD: begin
                dreq  <= '{start: 1'b1, is_signed: 1'b1, dividend: b, divisor: a};
                state <= S_DIV;
              end
              OP_CHOOSE: begin
                count <= count - 1'b1;
                if (cur.edge_count != '0) begin
                  dreq  <= '{start: 1'b1, is_signed: 1'b0, dividend: a,
                             divisor: WORD_W'(cur.edge_count)};
                  state <= S_DIV;
                end
              end
              OP_ROLL: begin
                count <= count - CW'(2);
                // depth must be in 1..size-2
                if (!b[WORD_W-1] && b != '0 &&
                    {1'b0, b} <= {{(WORD_W+1-CW){1'b0}}, count - CW'(2)}) begin
                  r_depth <= CW'(b);
                  r_base  <= count - CW'(2) - CW'(b);
                  dreq    <= '{start: 1'b1, is_signed: 1'b1, dividend: a, divisor: b};
                  state   <= S_RMOD;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            if (cur.operation == OP_CHOOSE) begin
              res_q.branch_index <= drsp.rem[EDGE_W-1:0];
            end else begin
              we      <= 1'b1;
              wr_addr <= AW'(count - CW'(2));
              wr_data <= (cur.operation == OP_DIV) ? drsp.quot : drsp.rem;
              count   <= count - 1'b1;
              res_q.stack_size <= SIZE_W'(count - 1'b1);
            end
            state <= S_DONE;
          end
        end
        S_RMOD: begin
          if (drsp.done) begin
            // Follow the cycle that starts at offset 0: entry i goes to (i+r) mod depth
            if (drsp.rem == '0) begin
              state <= S_DONE;
            end else begin
              r_shift <= drsp.rem[WORD_W-1] ? CW'(drsp.rem + b) : CW'(drsp.rem);
              r_start <= '0;
              r_src   <= '0;
              r_left  <= r_depth;
              rd_addr <= AW'(r_base);
              state   <= S_RRD;
            end
          end
        end
        S_RRD: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          // carry value forward along the cycle
          r_hold <= rd_data;
          r_dst  <= (r_sum >= {1'b0, r_depth}) ? CW'(r_sum - {1'b0, r_depth})
                                               : CW'(r_sum);
          state  <= S_RWR;
        end
        S_RWR: begin
          // write held value at dst, and load dst's old value next
          we      <= 1'b1;
          wr_addr <= AW'(r_base + r_dst);
          wr_data <= r_hold;
          r_left  <= r_left - 1'b1;
          if (r_left == CW'(1)) begin
            state <= S_DONE;
          end else if (r_dst == r_start) begin
            // cycle closed: begin the next one
            r_start <= r_start + 1'b1;
            r_src   <= r_start + 1'b1;
            rd_addr <= AW'(r_base + r_start + 1'b1);
            state   <= S_RRD;
          end else begin
            r_src   <= r_dst;
            rd_addr <= AW'(r_base + r_dst);
            state   <= S_RRD;
          end
        end
        S_DONE: begin
          if (cur.operation != OP_DIV && cur.operation != OP_MOD) begin
            res_q.stack_size <= SIZE_W'(count);
          end
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_stack_machine_execution_unit.sv @@
// ----------------------------------------------------------------------------
// tb_stack_machine_execution_unit: self-checking bench for the stack executor
// Drives command requests through the cmd channel, predicts every result with
// a local stack model and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_stack_machine_execution_unit;
  import smeu_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk;
  logic rst;

  smeu_cmd_if cmd_ch ();
  smeu_res_if res_ch ();

  stack_machine_execution_unit #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch.sink),
    .res(res_ch.source)
  );

  // Local stack copy
  logic [WORD_W-1:0] model_stack [DEPTH];
  int unsigned model_count;
  res_t expected_results [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_off_cycles;
  int unsigned mismatches;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Compute the result of one command and update the local stack
  function automatic res_t execute_command(cmd_t c);
    res_t r;
    int unsigned need;
    bit grows;
    logic [WORD_W-1:0] a, b, v;
    logic signed [WORD_W-1:0] sa, sb;
    logic [WORD_W-1:0] tmp [DEPTH];
    longint depth, rolls, rr;
    int unsigned n, d, start;
    r = '0;
    need = 0;
    grows = 1'b0;
    n = model_count;
    case (c.operation)
      OP_PUSH, OP_INCHAR: grows = 1'b1;
      OP_POP, OP_NOT, OP_OUTNUM, OP_OUTCHAR, OP_CHOOSE: need = 1;
      OP_DUP: begin
        need = 1;
        grows = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GREATER, OP_ROLL: need = 2;
      default: need = 0;
    endcase
    if (n < need) begin
      r.status = ST_UNDER;
    end else if (grows && n >= DEPTH) begin
      r.status = ST_OVER;
    end else if (need == 2) begin
      a = model_stack[n-1];
      b = model_stack[n-2];
      sa = a;
      sb = b;
      if ((c.operation == OP_DIV || c.operation == OP_MOD) && a == 0) begin
        r.status = ST_DIV0;
      end else if (c.operation == OP_ROLL) begin
        model_count = n - 2;
        rolls = longint'(sa);
        depth = longint'(sb);
        if (depth > 0 && depth <= model_count) begin
          rr = rolls % depth;
          if (rr < 0) rr += depth;
          d = 32'(depth);
          start = model_count - d;
          for (int unsigned i = 0; i < d; i++) tmp[i] = model_stack[start + i];
          for (int unsigned i = 0; i < d; i++)
            model_stack[start + ((i + rr) % depth)] = tmp[i];
        end
      end else begin
        case (c.operation)
          OP_ADD: v = b + a;
          OP_SUB: v = b - a;
          OP_MUL: v = b * a;
          OP_DIV: v = (sb == 32'sh80000000 && sa == -1) ? sb : sb / sa;
          OP_MOD: v = (sa == -1) ? 32'sd0 : sb % sa;
          default: v = (sb > sa) ? 32'd1 : 32'd0;
        endcase
        model_stack[n-2] = v;
        model_count = n - 1;
      end
    end else begin
      case (c.operation)
        OP_PUSH, OP_INCHAR: begin
          model_stack[n] = c.operand;
          model_count = n + 1;
        end
        OP_POP: model_count = n - 1;
        OP_NOT: model_stack[n-1] = (model_stack[n-1] == 0) ? 32'd1 : 32'd0;
        OP_DUP: begin
          model_stack[n] = model_stack[n-1];
          model_count = n + 1;
        end
        OP_OUTNUM, OP_OUTCHAR: begin
          r.emit_kind = (c.operation == OP_OUTNUM) ? EMIT_NUM : EMIT_CHAR;
          r.emit_value = model_stack[n-1];
          model_count = n - 1;
        end
        OP_CHOOSE: begin
          if (c.edge_count != 0)
            r.branch_index = EDGE_W'(model_stack[n-1] % c.edge_count);
          model_count = n - 1;
        end
        default: ;
      endcase
    end
    r.stack_size = SIZE_W'(model_count);
    return r;
  endfunction

  // Send one request, recording its expected result at acceptance
  task automatic send_command(logic [OP_W-1:0] op, logic [WORD_W-1:0] val,
                              logic [EDGE_W-1:0] edges);
    cmd_t c;
    c.operation = op;
    c.operand = val;
    c.edge_count = edges;
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    cmd_ch.payload = c;
    cmd_ch.valid = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_results.insert(expected_results.size(), execute_command(c));
    @(negedge clk);
    cmd_ch.valid = 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(8);
      4: return -$urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  // Check results in order
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.emit_kind !== want.emit_kind ||
            got.emit_value !== want.emit_value ||
            got.branch_index !== want.branch_index ||
            got.stack_size !== want.stack_size) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver readiness with optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_stack_machine_execution_unit: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(OP_POP, 0, 1);
    send_command(OP_ROLL, 0, 1);
    send_command(OP_PUSH, 32'h80000000, 1);
    send_command(OP_INCHAR, 32'hffffffff, 1);
    send_command(OP_DIV, 0, 1);
    send_command(OP_MOD, 0, 1);
    send_command(OP_PUSH, 0, 1);
    send_command(OP_DIV, 0, 1);
    send_command(OP_NOT, 0, 1);
    send_command(OP_DIV, 0, 1);
    send_command(OP_PUSH, 32'h80000000, 1);
    send_command(OP_PUSH, 32'hffffffff, 1);
    send_command(OP_MOD, 0, 1);
    send_command(OP_PUSH, 32'h7fffffff, 1);
    send_command(OP_GREATER, 0, 1);
    send_command(OP_DUP, 0, 1);
    send_command(OP_ADD, 0, 1);
    send_command(OP_MUL, 0, 1);
    send_command(OP_SUB, 0, 1);
    send_command(OP_PUSH, 32'hffffffff, 1);
    send_command(OP_CHOOSE, 0, 8'd255);
    send_command(OP_PUSH, 32'd7, 0);
    send_command(OP_CHOOSE, 0, 8'd0);
    send_command(OP_OUTNUM, 0, 1);
    send_command(4'd15, 32'h5a5a5a5a, 8'haa);
  endtask

  // Build up a few values then roll them with varied counts and depths
  task automatic test_roll_sequences(int unsigned reps);
    for (int unsigned k = 0; k < reps; k++) begin
      repeat ($urandom_range(1, 5)) send_command(OP_PUSH, random_word(), 1);
      send_command(OP_PUSH, $urandom_range(7) == 0 ? -$urandom_range(3) :
                   $urandom_range(1, model_count), 1);
      send_command(OP_PUSH, random_word(), 1);
      send_command(OP_ROLL, 0, 1);
      while (model_count > 6) send_command(OP_POP, 0, 1);
    end
  endtask

  task automatic test_random_commands(int unsigned count);
    logic [OP_W-1:0] op;
    for (int unsigned k = 0; k < count; k++) begin
      op = (model_count < 3 && $urandom_range(1)) ? OP_PUSH : OP_W'($urandom_range(15));
      send_command(op, random_word(), EDGE_W'($urandom_range(255)));
    end
  endtask

  // Fill to capacity to reach overflow, roll deep, then drain a little
  task automatic test_overflow();
    while (model_count < DEPTH) send_command(OP_PUSH, $urandom, 1);
    send_command(OP_PUSH, 1, 1);
    send_command(OP_DUP, 0, 1);
    send_command(OP_INCHAR, 1, 1);
    send_command(OP_POP, 0, 1);
    send_command(OP_POP, 0, 1);
    send_command(OP_PUSH, DEPTH - 2, 1);
    send_command(OP_PUSH, 32'hfffffffb, 1);
    send_command(OP_ROLL, 0, 1);
    send_command(OP_PUSH, 3, 1);
    send_command(OP_PUSH, 2, 1);
    send_command(OP_ROLL, 0, 1);
    repeat (8) send_command(OP_OUTCHAR, 0, 1);
  endtask

  // Hold the receiver off while requests keep coming
  task automatic test_backpressure();
    hold_off_cycles = 300;
    test_random_commands(20);
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    res_ch.ready = 1'b0;
    model_count = 0;
    mismatches = 0;
    idle_cycles = 0;
    hold_off_cycles = 0;
    src_idle_pct = 20;
    snk_idle_pct = 58;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_roll_sequences(5);
    test_random_commands(20);
    test_backpressure();
    src_idle_pct = 58;
    snk_idle_pct = 20;
    test_roll_sequences(5);
    test_random_commands(20);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_commands(15);
    test_overflow();
    wait_drain();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_stack_machine_execution_unit: done, clean");
    else
      $display("tb_stack_machine_execution_unit: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/smeu_pkg.sv
hdl/smeu_if.sv
hdl/smeu_div.sv
hdl/stack_machine_execution_unit.sv
test/tb_stack_machine_execution_unit.sv
